### rtl/smtp_session_tracker_assert.svh
// Assertion macros shared by the session tracker RTL.
`ifndef SMTP_SESSION_TRACKER_ASSERT_SVH
`define SMTP_SESSION_TRACKER_ASSERT_SVH
// Same-cycle implication under the block clock and reset.
`define SST_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sst check failed");
// Next-cycle implication under the block clock and reset.
`define SST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sst check failed");
`endif

### rtl/sst_pkg.sv
// Types and constants shared by the session tracker modules.
package sst_pkg;

	// Command codes.
	localparam logic [4:0] CMD_EHLO = 5'd0;
	localparam logic [4:0] CMD_HELO = 5'd1;
	localparam logic [4:0] CMD_MAIL = 5'd2;
	localparam logic [4:0] CMD_SEND = 5'd3;
	localparam logic [4:0] CMD_SOML = 5'd4;
	localparam logic [4:0] CMD_SAML = 5'd5;
	localparam logic [4:0] CMD_RCPT = 5'd6;
	localparam logic [4:0] CMD_DATA = 5'd7;
	localparam logic [4:0] CMD_RSET = 5'd8;
	localparam logic [4:0] CMD_QUIT = 5'd9;
	localparam logic [4:0] CMD_AUTH = 5'd10;
	localparam logic [4:0] CMD_TURN = 5'd11;
	localparam logic [4:0] CMD_STLS = 5'd12;
	localparam logic [4:0] CMD_XTLS = 5'd13;
	localparam logic [4:0] CMD_EOD  = 5'd27;
	localparam logic [4:0] CMD_ANSW = 5'd28;
	localparam logic [4:0] CMD_CONN = 5'd29;
	localparam logic [4:0] CMD_NONE = 5'd30;
	localparam logic [4:0] CMD_UNK  = 5'd31;

	// Session phases.
	localparam logic [3:0] PH_CONNECTED = 4'd0;
	localparam logic [3:0] PH_INITIATED = 4'd1;
	localparam logic [3:0] PH_NOTAVAIL  = 4'd2;
	localparam logic [3:0] PH_READY     = 4'd3;
	localparam logic [3:0] PH_MAILOK    = 4'd4;
	localparam logic [3:0] PH_RCPTOK    = 4'd5;
	localparam logic [3:0] PH_INDATA    = 4'd6;
	localparam logic [3:0] PH_AFTERDATA = 4'd7;
	localparam logic [3:0] PH_INAUTH    = 4'd8;
	localparam logic [3:0] PH_INTLS     = 4'd9;
	localparam logic [3:0] PH_QUIT      = 4'd10;
	localparam logic [3:0] PH_AFTERGAP  = 4'd11;
	localparam logic [3:0] PH_GAPREC    = 4'd12;

	// Anomaly flag bits.
	localparam logic [5:0] FL_ORDER    = 6'd1;
	localparam logic [5:0] FL_UNKCMD   = 6'd2;
	localparam logic [5:0] FL_BADCODE  = 6'd4;
	localparam logic [5:0] FL_MISMATCH = 6'd8;
	localparam logic [5:0] FL_UCMD     = 6'd16;
	localparam logic [5:0] FL_UREPLY   = 6'd32;

	// Reply codes with a role of their own.
	localparam logic [9:0] RC_NONE = 10'd0;
	localparam logic [9:0] RC_MIN  = 10'd100;
	localparam logic [9:0] RC_MAX  = 10'd599;
	localparam logic [9:0] RC_220  = 10'd220;
	localparam logic [9:0] RC_221  = 10'd221;
	localparam logic [9:0] RC_250  = 10'd250;
	localparam logic [9:0] RC_334  = 10'd334;
	localparam logic [9:0] RC_354  = 10'd354;
	localparam logic [9:0] RC_421  = 10'd421;
	localparam logic [9:0] RC_554  = 10'd554;

	// Configuration register indexes.
	localparam logic REG_PIPE_EN = 1'b0;
	localparam logic REG_QLIMIT  = 1'b1;

	localparam logic [10:0] QLIMIT_RESET = 11'd1000;

	// One classified line event as it waits between front and back.
	typedef struct packed {
		logic       gap;
		logic       from_orig;
		logic [4:0] cmd;
		logic       dot;
		logic [9:0] rc;
		logic       cont;
		logic       adv;
		logic       bad_rc;
		logic       unk_cmd;
	} item_t;

	// One result word.
	typedef struct packed {
		logic       ovf;
		logic       data_line;
		logic       tls;
		logic       mail_end;
		logic       mail_begin;
		logic [5:0] flags;
		logic       rep_cont;
		logic [4:0] rep_cmd;
		logic       rep_valid;
		logic [4:0] req_cmd;
		logic       req_valid;
		logic [3:0] phase;
	} result_t;

	function automatic logic helo_fail(input logic [9:0] rc);
		case (rc)
			10'd421, 10'd500, 10'd501, 10'd504, 10'd550: helo_fail = 1'b1;
			default: helo_fail = 1'b0;
		endcase
	endfunction

	function automatic logic mail_fail(input logic [9:0] rc);
		case (rc)
			10'd421, 10'd451, 10'd452, 10'd500, 10'd501, 10'd503, 10'd550, 10'd552,
			10'd553: mail_fail = 1'b1;
			default: mail_fail = 1'b0;
		endcase
	endfunction

	function automatic logic rcpt_ok(input logic [9:0] rc);
		case (rc)
			10'd250, 10'd251, 10'd421, 10'd450, 10'd451, 10'd452, 10'd500, 10'd501,
			10'd503, 10'd550, 10'd551, 10'd552, 10'd553, 10'd554: rcpt_ok = 1'b1;
			default: rcpt_ok = 1'b0;
		endcase
	endfunction

	function automatic logic data_fail(input logic [9:0] rc);
		case (rc)
			10'd500, 10'd501, 10'd503, 10'd451, 10'd554: data_fail = 1'b1;
			default: data_fail = 1'b0;
		endcase
	endfunction

	function automatic logic eod_ok(input logic [9:0] rc);
		case (rc)
			10'd250, 10'd421, 10'd451, 10'd452, 10'd552, 10'd554: eod_ok = 1'b1;
			default: eod_ok = 1'b0;
		endcase
	endfunction

endpackage

### rtl/sst_front.sv
// Front end: accepts line words, classifies them and queues them for the back end.
module sst_front import sst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t      fifo_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	item_t      cls;
	logic       push;

	always_comb begin
		cls.gap       = s_tuser;
		cls.from_orig = s_tdata[0];
		cls.cmd       = s_tdata[5:1];
		cls.dot       = s_tdata[6];
		cls.rc        = s_tdata[16:7];
		cls.cont      = s_tdata[17];
		cls.adv       = s_tdata[18];
		cls.bad_rc    = (s_tdata[16:7] < RC_MIN) || (s_tdata[16:7] > RC_MAX);
		cls.unk_cmd   = s_tdata[5:1] >= CMD_EOD;
	end

	assign s_tready = cnt_q != 3'd4;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = cnt_q != 3'd0;
	assign q_item   = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (q_pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, q_pop};
		end
	end

endmodule

### rtl/sst_back.sv
// Back end: session state, pending command memory and the result register.
module sst_back import sst_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic [10:0]                  cfg_wdata,
	input  logic                         q_valid,
	input  item_t                        q_item,
	output logic                         q_pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,
	output logic [$clog2(DEPTH+1)-1:0]   pend_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > 11) ? CW : 11;
	localparam logic [LW-1:0] LIM_MAX = LW'(DEPTH);
	localparam logic [CW:0]   SUM_DEPTH = (CW+1)'(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_SPARE = 3'b100
	} fsm_t;

	fsm_t        st_q;
	logic [4:0]  mem_q [DEPTH];
	logic [4:0]  rdata_q;

	logic [3:0]  ph_q;
	logic        ec_q, es_q, os_q, ps_q, mo_q;
	logic [4:0]  hd_q, la_q;
	logic [9:0]  cc_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] qrd_q;
	logic [10:0] qlim_q;
	result_t     res_q;

	logic [3:0]  ph, st0;
	logic        ec, es, os, ps, mo, snd, do_upd, we;
	logic [4:0]  hd, la, uc;
	logic [9:0]  cc, urc;
	logic [CW-1:0] cnt;
	logic [AW-1:0] qrd, waddr;
	logic [LW-1:0] lim;
	logic [CW:0] sum;
	logic [4:0]  wdata;
	result_t     r;
	logic        commit;

	assign commit     = (st_q == ST_EXEC) && (!m_tvalid || m_tready);
	assign q_pop      = commit;
	assign m_tdata    = {4'b0, res_q};
	assign pend_count = cnt_q;

	always_comb begin
		ph = ph_q; ec = ec_q; es = es_q; os = os_q; ps = ps_q; mo = mo_q;
		hd = hd_q; la = la_q; cc = cc_q; cnt = cnt_q; qrd = qrd_q;
		r = '0;
		r.rep_cmd = CMD_NONE;
		do_upd = 1'b0; uc = CMD_NONE; urc = RC_NONE;
		we = 1'b0; waddr = '0; wdata = q_item.cmd;
		snd = 1'b0; st0 = ph_q; sum = '0;
		lim = LW'(qlim_q);
		if (lim == '0) lim = LW'(1);
		if (lim > LIM_MAX) lim = LIM_MAX;

		if (q_item.gap) begin
			ec = 1'b1; es = 1'b1;
			if (ph == PH_INDATA && mo) begin mo = 1'b0; r.mail_end = 1'b1; end
			cnt = '0; qrd = '0; hd = CMD_NONE; la = CMD_NONE;
			ph = PH_AFTERGAP;
		end else if (ph != PH_INTLS) begin
			snd = os ? q_item.from_orig : !q_item.from_orig;
			if (!ps && ((snd && !ec) || (!snd && !es))) begin
				r.flags |= FL_ORDER; ec = 1'b1; es = 1'b1;
			end
			if (snd) begin
				// Sender line: pick the command it stands for, if any.
				if (ph == PH_AFTERGAP) begin
				end else if (ph == PH_INDATA && q_item.dot) begin
					uc = CMD_EOD; do_upd = 1'b1;
					ec = 1'b0; es = 1'b1;
				end else if (ph == PH_INDATA) begin
					es = 1'b0;
					if (!mo) begin
						ph = PH_INDATA;
						mo = 1'b1; r.mail_begin = 1'b1;
					end
					r.data_line = 1'b1;
				end else if (ph == PH_INAUTH) begin
					uc = CMD_ANSW; do_upd = 1'b1;
				end else begin
					ec = 1'b0; es = 1'b1;
					if (q_item.unk_cmd) begin
						r.flags |= FL_UNKCMD; ec = 1'b1; es = 1'b1;
					end else begin
						uc = q_item.cmd; do_upd = 1'b1;
					end
				end
				if (do_upd) begin
					r.req_valid = 1'b1;
					r.req_cmd   = uc;
					wdata       = uc;
					if (!ps || hd == CMD_NONE) begin
						hd = uc;
					end else begin
						if (LW'(cnt) >= lim) begin
							cnt = '0; qrd = '0; r.ovf = 1'b1;
						end
						sum = {1'b0, CW'(qrd)} + {1'b0, cnt};
						if (sum >= SUM_DEPTH) sum = sum - SUM_DEPTH;
						waddr = sum[AW-1:0];
						we = 1'b1;
						cnt = cnt + CW'(1);
					end
				end
			end else if (q_item.bad_rc) begin
				r.flags |= FL_BADCODE; ec = 1'b1; es = 1'b1;
			end else begin
				if (cc != RC_NONE && q_item.rc != cc) begin
					r.flags |= FL_MISMATCH; ec = 1'b1; es = 1'b1;
					cc = RC_NONE;
				end
				if (cc == RC_NONE) begin
					// A new reply answers the head command and pulls the next one.
					if (ph == PH_AFTERGAP) begin
						ph = PH_GAPREC; r.req_valid = 1'b1; r.req_cmd = CMD_UNK;
					end
					uc = hd; la = hd; hd = CMD_NONE;
					if (ps && cnt != '0) begin
						hd = rdata_q;
						qrd = (qrd == AW'(DEPTH - 1)) ? '0 : qrd + AW'(1);
						cnt = cnt - CW'(1);
					end
					urc = q_item.rc; do_upd = 1'b1;
				end
			end
		end

		if (do_upd) begin
			st0 = ph;
			if (st0 == PH_QUIT && urc == RC_NONE) begin
				r.flags |= FL_UCMD; ec = 1'b1; es = 1'b1;
			end
			case (uc) inside
				CMD_CONN: begin
					if (urc == RC_NONE) begin
						if (st0 != PH_CONNECTED) begin
							r.flags |= FL_UCMD; ec = 1'b1; es = 1'b1;
						end
						ph = PH_INITIATED;
					end else if (urc == RC_220) begin
					end else if (urc == RC_421 || urc == RC_554) begin
						ph = PH_NOTAVAIL;
					end else begin
						r.flags |= FL_UREPLY; ec = 1'b1; es = 1'b1;
					end
				end
				CMD_EHLO, CMD_HELO: begin
					if (urc == RC_NONE) begin
						if (st0 != PH_INITIATED) begin
							r.flags |= FL_UCMD; ec = 1'b1; es = 1'b1;
						end
						ph = PH_READY;
					end else if (urc == RC_250) begin
					end else if (helo_fail(urc)) begin
						ph = PH_INITIATED;
					end else begin
						r.flags |= FL_UREPLY; ec = 1'b1; es = 1'b1;
					end
				end
				CMD_MAIL, CMD_SEND, CMD_SOML, CMD_SAML: begin
					if (urc == RC_NONE) begin
						if (st0 != PH_READY) begin
							r.flags |= FL_UCMD; ec = 1'b1; es = 1'b1;
						end
						ph = PH_MAILOK;
					end else if (urc == RC_250) begin
					end else if (mail_fail(urc)) begin
						if (st0 != PH_INDATA) ph = PH_READY;
					end else begin
						r.flags |= FL_UREPLY; ec = 1'b1; es = 1'b1;
					end
				end
				CMD_RCPT: begin
					if (urc == RC_NONE) begin
						if (st0 != PH_MAILOK && st0 != PH_RCPTOK) begin
							r.flags |= FL_UCMD; ec = 1'b1; es = 1'b1;
						end
						ph = PH_RCPTOK;
					end else if (!rcpt_ok(urc)) begin
						r.flags |= FL_UREPLY; ec = 1'b1; es = 1'b1;
					end
				end
				CMD_DATA: begin
					if (urc == RC_NONE) begin
						if (st0 != PH_RCPTOK) begin
							r.flags |= FL_UCMD; ec = 1'b1; es = 1'b1;
						end
						ph = PH_INDATA;
						if (mo) r.mail_end = 1'b1;
						mo = 1'b1; r.mail_begin = 1'b1;
					end else if (urc == RC_354) begin
					end else if (urc == RC_421) begin
						if (st0 == PH_INDATA && mo) begin mo = 1'b0; r.mail_end = 1'b1; end
						ph = PH_QUIT;
					end else begin
						if (!data_fail(urc)) begin
							r.flags |= FL_UREPLY; ec = 1'b1; es = 1'b1;
						end
						if (st0 == PH_INDATA && mo) begin mo = 1'b0; r.mail_end = 1'b1; end
						ph = PH_READY;
					end
				end
				CMD_EOD: begin
					if (urc == RC_NONE) begin
						if (st0 != PH_INDATA) begin
							r.flags |= FL_UCMD; ec = 1'b1; es = 1'b1;
						end
						if (mo) begin mo = 1'b0; r.mail_end = 1'b1; end
						ph = PH_AFTERDATA;
					end else begin
						if (!eod_ok(urc)) begin
							r.flags |= FL_UREPLY; ec = 1'b1; es = 1'b1;
						end
						ph = PH_READY;
					end
				end
				CMD_RSET: begin
					if (urc == RC_NONE) ph = PH_READY;
					else if (urc != RC_250) begin
						r.flags |= FL_UREPLY; ec = 1'b1; es = 1'b1;
					end
				end
				CMD_QUIT: begin
					if (urc == RC_NONE) ph = PH_QUIT;
					else if (urc != RC_221) begin
						r.flags |= FL_UREPLY; ec = 1'b1; es = 1'b1;
					end
				end
				CMD_AUTH, CMD_ANSW: begin
					if (st0 != ((uc == CMD_AUTH) ? PH_READY : PH_INAUTH)) begin
						r.flags |= FL_UCMD; ec = 1'b1; es = 1'b1;
					end
					if (urc == RC_NONE) begin
					end else if (urc == RC_334) ph = PH_INAUTH;
					else ph = PH_INITIATED;
				end
				CMD_TURN: begin
					if (st0 != PH_READY) begin
						r.flags |= FL_UCMD; ec = 1'b1; es = 1'b1;
					end
					if (urc == RC_250) begin
						os = !os; ph = PH_CONNECTED; ec = 1'b0; es = 1'b1;
					end
				end
				CMD_STLS, CMD_XTLS: begin
					if (st0 != PH_READY) begin
						r.flags |= FL_UCMD; ec = 1'b1; es = 1'b1;
					end
					if (urc == RC_220) begin
						ph = PH_INTLS; ec = 1'b1; es = 1'b1; r.tls = 1'b1;
					end
				end
				default: begin
					if (st0 == PH_GAPREC && urc == RC_354) begin
						ph = PH_INDATA;
						if (mo) r.mail_end = 1'b1;
						mo = 1'b1; r.mail_begin = 1'b1;
					end
				end
			endcase
		end

		// Reply bookkeeping that follows the state update.
		if (!q_item.gap && ph_q != PH_INTLS && !snd && !q_item.bad_rc) begin
			if (q_item.cont) cc = q_item.rc;
			else begin cc = RC_NONE; ec = 1'b1; es = 1'b0; end
			r.rep_valid = 1'b1;
			r.rep_cmd   = la;
			r.rep_cont  = cc != RC_NONE;
			if (la == CMD_EHLO && q_item.rc == RC_250 && q_item.adv) ps = 1'b1;
		end
		r.phase = ph;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE) rdata_q <= mem_q[qrd_q];
		if (commit && we) mem_q[waddr] <= wdata;
		if (commit) res_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			m_tvalid <= 1'b0;
			ph_q     <= PH_INITIATED;
			ec_q     <= 1'b0;
			es_q     <= 1'b1;
			os_q     <= 1'b1;
			ps_q     <= 1'b1;
			mo_q     <= 1'b0;
			hd_q     <= CMD_CONN;
			la_q     <= CMD_NONE;
			cc_q     <= RC_NONE;
			cnt_q    <= '0;
			qrd_q    <= '0;
			qlim_q   <= QLIMIT_RESET;
		end else begin
			unique case (st_q)
				ST_IDLE: if (q_valid) st_q <= ST_EXEC;
				ST_EXEC: if (commit) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
			if (commit) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (commit) begin
				ph_q <= ph; ec_q <= ec; es_q <= es; os_q <= os; ps_q <= ps;
				mo_q <= mo; hd_q <= hd; la_q <= la; cc_q <= cc;
				cnt_q <= cnt; qrd_q <= qrd;
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_PIPE_EN: ps_q <= cfg_wdata[0];
					REG_QLIMIT:  qlim_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

### rtl/smtp_session_tracker.sv
// Top level of the passive SMTP session tracker.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata line fields, s_tuser content-gap mark
//  m_*       out  m_tvalid/m_tready    m_tdata one result word per input word
//  cfg_*     in   cfg_we               cfg_idx register index, cfg_wdata value
//
// For each input word the back end reads the pending command memory at the
// queue head, then updates the session state and writes the result register
// once the output register is free. The front accepts words into a four-entry
// queue, so input keeps flowing while a result waits on m_tready, until the
// queue fills. Reset is asynchronous and clears all control state; the pending
// command memory needs no clearing since only written entries are ever read.
module smtp_session_tracker import sst_pkg::*; #(
	parameter int QUEUE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] from_orig, [5:1] command word, [6] is_lone_dot, [16:7] reply digits,
	// [17] reply_continued, [18] advertises_pipelining, rest zero
	input  logic [23:0] s_tdata,
	// [0] mode: high for a content gap
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] session_state, [4] request_valid, [9:5] request_cmd, [10] reply_valid,
	// [15:11] replied_cmd, [16] reply_continues, [22:17] unexpected_flags,
	// [23] mail_begin, [24] mail_end, [25] tls_started, [26] is_data_line,
	// [27] queue_overflow, rest zero
	output logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [10:0] cfg_wdata
);

`include "smtp_session_tracker_assert.svh"

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          q_valid;
	logic          q_pop;
	item_t         q_item;
	logic [CW-1:0] pend_count;

	// The front classifies each word as it arrives and holds it until the
	// back end is ready for it.
	sst_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// The back end owns the session state and the pipelined command queue.
	sst_back #(.DEPTH(QUEUE_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.pend_count (pend_count)
	);

	// The pending count never passes the memory depth.
	`SST_IMPLY(a_pend_bound, 1'b1, pend_count <= CW'(QUEUE_DEPTH))
	// A word without a request carries a zero request command.
	`SST_IMPLY(a_req_idle, m_tvalid && !m_tdata[4], m_tdata[9:5] == 5'd0)
	// A word without a reply names no command and no continuation.
	`SST_IMPLY(a_rep_idle, m_tvalid && !m_tdata[10], m_tdata[15:11] == CMD_NONE && !m_tdata[16])
	// A word taken from the queue always leaves a result pending next cycle.
	`SST_NEXT(a_pop_result, q_pop, m_tvalid)

endmodule

### sim/tb_smtp_session_tracker.sv
// Self-checking testbench for the passive SMTP session tracker.
`timescale 1ns / 100ps

module tb_smtp_session_tracker import sst_pkg::*; ();

	localparam int DEPTH = 1024;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [0] from_orig, [5:1] command word, [6] is_lone_dot, [16:7] reply digits,
	// [17] reply_continued, [18] advertises_pipelining, rest zero
	logic [23:0] s_tdata = '0;
	// [0] mode: high for a content gap
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [3:0] session_state, [4] request_valid, [9:5] request_cmd, [10] reply_valid,
	// [15:11] replied_cmd, [16] reply_continues, [22:17] unexpected_flags,
	// [23] mail_begin, [24] mail_end, [25] tls_started, [26] is_data_line,
	// [27] queue_overflow, rest zero
	logic [31:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = 1'b0;
	logic [10:0] cfg_wdata = '0;

	smtp_session_tracker dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// The limit allows for the slowest words many times over.
	initial begin
		#5_000_000;
		$display("[smtp_session_tracker] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Session model. It mirrors the tracker state and is advanced once for
	// every word that the tracker accepts, so its view is always current.
	// ------------------------------------------------------------------
	logic        pipe_en;
	logic [10:0] qlimit;
	logic [3:0]  ph;
	logic        exp_cli, exp_srv, orig_snd, pipe_seen, mail_open;
	logic [4:0]  head_cmd, last_ans;
	logic [9:0]  cont_code;
	logic [4:0]  pend_cmds [DEPTH];
	int          rd_ptr, pend_cnt;
	result_t     res;

	result_t     results_due [$];
	int          errors = 0;
	int          lines_sent = 0;

	task automatic model_reset();
		pipe_en = 1'b1;
		qlimit = QLIMIT_RESET;
		ph = PH_INITIATED;
		exp_cli = 1'b0;
		exp_srv = 1'b1;
		orig_snd = 1'b1;
		head_cmd = CMD_CONN;
		last_ans = CMD_NONE;
		cont_code = '0;
		pipe_seen = 1'b1;
		rd_ptr = 0;
		pend_cnt = 0;
		mail_open = 1'b0;
	endtask

	// Any anomaly makes both directions acceptable again.
	task automatic raise(input logic [5:0] f);
		res.flags |= f;
		exp_cli = 1'b1;
		exp_srv = 1'b1;
	endtask

	task automatic close_mail();
		if (mail_open) begin
			mail_open = 1'b0;
			res.mail_end = 1'b1;
		end
	endtask

	// A new data section closes a still open one first.
	task automatic open_mail();
		ph = PH_INDATA;
		close_mail();
		mail_open = 1'b1;
		res.mail_begin = 1'b1;
	endtask

	task automatic push_cmd(input logic [4:0] c);
		int lim;
		lim = qlimit;
		if (!pipe_seen || head_cmd == CMD_NONE) begin
			head_cmd = c;
			return;
		end
		if (lim < 1) lim = 1;
		if (lim > DEPTH) lim = DEPTH;
		if (pend_cnt >= lim) begin
			pend_cnt = 0;
			rd_ptr = 0;
			res.ovf = 1'b1;
		end
		pend_cmds[(rd_ptr + pend_cnt) % DEPTH] = c;
		pend_cnt++;
	endtask

	function automatic bit code_in(input logic [9:0] rc, input int list[]);
		foreach (list[i])
			if (rc == list[i]) return 1'b1;
		return 1'b0;
	endfunction

	// Command and reply transition table; rc of zero stands for the command
	// itself, any other value for the reply that answers it.
	task automatic advance_phase(input logic [4:0] c, input logic [9:0] rc);
		logic [3:0] st;
		st = ph;
		if (st == PH_QUIT && rc == RC_NONE) raise(FL_UCMD);
		case (c)
			CMD_CONN: begin
				if (rc == RC_NONE) begin
					if (st != PH_CONNECTED) raise(FL_UCMD);
					ph = PH_INITIATED;
				end else if (rc == RC_220) begin
				end else if (rc == RC_421 || rc == RC_554) ph = PH_NOTAVAIL;
				else raise(FL_UREPLY);
			end
			CMD_EHLO, CMD_HELO: begin
				if (rc == RC_NONE) begin
					if (st != PH_INITIATED) raise(FL_UCMD);
					ph = PH_READY;
				end else if (rc == RC_250) begin
				end else if (code_in(rc, '{421, 500, 501, 504, 550})) ph = PH_INITIATED;
				else raise(FL_UREPLY);
			end
			CMD_MAIL, CMD_SEND, CMD_SOML, CMD_SAML: begin
				if (rc == RC_NONE) begin
					if (st != PH_READY) raise(FL_UCMD);
					ph = PH_MAILOK;
				end else if (rc == RC_250) begin
				end else if (code_in(rc, '{421, 451, 452, 500, 501, 503, 550, 552, 553})) begin
					if (st != PH_INDATA) ph = PH_READY;
				end else raise(FL_UREPLY);
			end
			CMD_RCPT: begin
				if (rc == RC_NONE) begin
					if (st != PH_MAILOK && st != PH_RCPTOK) raise(FL_UCMD);
					ph = PH_RCPTOK;
				end else if (!code_in(rc, '{250, 251, 421, 450, 451, 452, 500, 501, 503,
						550, 551, 552, 553, 554})) raise(FL_UREPLY);
			end
			CMD_DATA: begin
				if (rc == RC_NONE) begin
					if (st != PH_RCPTOK) raise(FL_UCMD);
					open_mail();
				end else if (rc == RC_354) begin
				end else if (rc == RC_421) begin
					if (st == PH_INDATA) close_mail();
					ph = PH_QUIT;
				end else begin
					if (!code_in(rc, '{500, 501, 503, 451, 554})) raise(FL_UREPLY);
					if (st == PH_INDATA) close_mail();
					ph = PH_READY;
				end
			end
			CMD_EOD: begin
				if (rc == RC_NONE) begin
					if (st != PH_INDATA) raise(FL_UCMD);
					close_mail();
					ph = PH_AFTERDATA;
				end else begin
					if (!code_in(rc, '{250, 421, 451, 452, 552, 554})) raise(FL_UREPLY);
					ph = PH_READY;
				end
			end
			CMD_RSET: begin
				if (rc == RC_NONE) ph = PH_READY;
				else if (rc != RC_250) raise(FL_UREPLY);
			end
			CMD_QUIT: begin
				if (rc == RC_NONE) ph = PH_QUIT;
				else if (rc != RC_221) raise(FL_UREPLY);
			end
			CMD_AUTH, CMD_ANSW: begin
				if (st != ((c == CMD_AUTH) ? PH_READY : PH_INAUTH)) raise(FL_UCMD);
				if (rc == RC_NONE) begin
				end else if (rc == RC_334) ph = PH_INAUTH;
				else ph = PH_INITIATED;
			end
			CMD_TURN: begin
				if (st != PH_READY) raise(FL_UCMD);
				if (rc == RC_250) begin
					orig_snd = ~orig_snd;
					ph = PH_CONNECTED;
					exp_cli = 1'b0;
					exp_srv = 1'b1;
				end
			end
			CMD_STLS, CMD_XTLS: begin
				if (st != PH_READY) raise(FL_UCMD);
				if (rc == RC_220) begin
					ph = PH_INTLS;
					exp_cli = 1'b1;
					exp_srv = 1'b1;
					res.tls = 1'b1;
				end
			end
			default: begin
				// After a gap the first 354 means the data section went on.
				if (st == PH_GAPREC && rc == RC_354) open_mail();
			end
		endcase
	endtask

	task automatic take_reply(input logic [9:0] rc);
		logic [4:0] c;
		if (ph == PH_AFTERGAP) begin
			ph = PH_GAPREC;
			res.req_valid = 1'b1;
			res.req_cmd = CMD_UNK;
		end
		c = head_cmd;
		last_ans = head_cmd;
		head_cmd = CMD_NONE;
		if (pipe_seen && pend_cnt > 0) begin
			head_cmd = pend_cmds[rd_ptr];
			rd_ptr = (rd_ptr + 1) % DEPTH;
			pend_cnt--;
		end
		advance_phase(c, rc);
	endtask

	task automatic client_line(input logic [4:0] cmd, input logic dot);
		logic [4:0] c;
		bit have;
		c = CMD_UNK;
		have = 1'b0;
		if (ph == PH_AFTERGAP) begin
		end else if (ph == PH_INDATA && dot) begin
			c = CMD_EOD;
			have = 1'b1;
			push_cmd(c);
			exp_cli = 1'b0;
			exp_srv = 1'b1;
		end else if (ph == PH_INDATA) begin
			exp_srv = 1'b0;
			if (!mail_open) open_mail();
			res.data_line = 1'b1;
		end else if (ph == PH_INAUTH) begin
			c = CMD_ANSW;
			have = 1'b1;
			push_cmd(c);
		end else begin
			exp_cli = 1'b0;
			exp_srv = 1'b1;
			if (cmd >= CMD_EOD) raise(FL_UNKCMD);
			else begin
				c = cmd;
				have = 1'b1;
				push_cmd(c);
			end
		end
		if (have) begin
			res.req_valid = 1'b1;
			res.req_cmd = c;
			advance_phase(c, RC_NONE);
		end
	endtask

	task automatic server_line(input logic [9:0] rc, input logic cont, input logic adv);
		if (rc < RC_MIN || rc > RC_MAX) begin
			raise(FL_BADCODE);
			return;
		end
		if (cont_code != 0 && rc != cont_code) begin
			raise(FL_MISMATCH);
			cont_code = '0;
		end
		if (cont_code == 0) take_reply(rc);
		if (cont) cont_code = rc;
		else begin
			cont_code = '0;
			exp_cli = 1'b1;
			exp_srv = 1'b0;
		end
		res.rep_valid = 1'b1;
		res.rep_cmd = last_ans;
		res.rep_cont = (cont_code != 0);
		if (last_ans == CMD_EHLO && rc == RC_250 && adv) pipe_seen = 1'b1;
	endtask

	// Works out the result word of one accepted line or gap.
	task automatic track_line(input logic gap, input logic fo, input logic [4:0] cmd,
			input logic dot, input logic [9:0] rc, input logic cont, input logic adv);
		logic snd;
		res = '0;
		res.rep_cmd = CMD_NONE;
		if (gap) begin
			exp_cli = 1'b1;
			exp_srv = 1'b1;
			if (ph == PH_INDATA) close_mail();
			pend_cnt = 0;
			rd_ptr = 0;
			head_cmd = CMD_NONE;
			last_ans = CMD_NONE;
			ph = PH_AFTERGAP;
		end else if (ph != PH_INTLS) begin
			snd = orig_snd ? fo : ~fo;
			if (!pipe_seen && ((snd && !exp_cli) || (!snd && !exp_srv))) raise(FL_ORDER);
			if (snd) client_line(cmd, dot);
			else server_line(rc, cont, adv);
		end
		res.phase = ph;
		results_due.insert(results_due.size(), res);
	endtask

	// ------------------------------------------------------------------
	// Input side. Words go out in bursts of random length; most bursts are
	// preceded by a gap in which tvalid is held low.
	// ------------------------------------------------------------------
	int burst_left = 0;

	task automatic send_word(input logic gap, input logic fo, input logic [4:0] cmd,
			input logic dot, input logic [9:0] rc, input logic cont, input logic adv);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, adv, cont, rc, dot, cmd, fo};
		s_tuser <= gap;
		do @(posedge clk); while (!s_tready);
		lines_sent++;
		track_line(gap, fo, cmd, dot, rc, cont, adv);
	endtask

	// Lines as seen from the two roles; the model knows which side sends.
	task automatic client(input logic [4:0] cmd, input logic dot = 1'b0);
		send_word(1'b0, orig_snd, cmd, dot, $urandom, $urandom, $urandom);
	endtask

	task automatic server(input logic [9:0] rc, input logic cont = 1'b0,
			input logic adv = 1'b0);
		send_word(1'b0, ~orig_snd, $urandom, $urandom, rc, cont, adv);
	endtask

	task automatic content_gap();
		send_word(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Waits until every result has come back, then lets the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [10:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PIPE_EN) begin
			pipe_en = val[0];
			pipe_seen = val[0];
		end else qlimit = val;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Output side. The stall pattern is redrawn when its counter runs out; a long hold-off
	// can be requested by the tests and is counted here.
	// ------------------------------------------------------------------
	bit hold_req = 1'b0;
	int hold_left = 0;
	int pattern = 0;
	int pat_cnt = 0;

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 300;
		end
		if (pat_cnt == 0) begin
			pattern = $urandom_range(0, 3);
			pat_cnt = 40;
		end
		pat_cnt--;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (pattern)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Compares each result word with the oldest expectation.
	always @(posedge clk) begin
		result_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[27:0];
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word %h", $time, m_tdata);
			end else begin
				want = results_due[0];
				results_due.delete(0);
				check_field("session_state", want.phase, got.phase);
				check_field("request_valid", want.req_valid, got.req_valid);
				check_field("request_cmd", want.req_cmd, got.req_cmd);
				check_field("reply_valid", want.rep_valid, got.rep_valid);
				check_field("replied_cmd", want.rep_cmd, got.rep_cmd);
				check_field("reply_continues", want.rep_cont, got.rep_cont);
				check_field("unexpected_flags", want.flags, got.flags);
				check_field("mail_begin", want.mail_begin, got.mail_begin);
				check_field("mail_end", want.mail_end, got.mail_end);
				check_field("tls_started", want.tls, got.tls);
				check_field("is_data_line", want.data_line, got.data_line);
				check_field("queue_overflow", want.ovf, got.ovf);
				check_field("padding", 0, m_tdata[31:28]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------
	localparam int REPLY_CODES [20] = '{220, 221, 250, 251, 334, 354, 421, 450, 451, 452,
		500, 501, 503, 504, 550, 551, 552, 553, 554, 235};

	function automatic logic [9:0] some_reply();
		if ($urandom_range(0, 9) == 0) return $urandom_range(100, 599);
		return REPLY_CODES[$urandom_range(0, 19)];
	endfunction

	// A command that fits the current phase most of the time.
	function automatic logic [4:0] fitting_cmd();
		if ($urandom_range(0, 4) == 0) return $urandom_range(0, 31);
		case (ph)
			PH_INITIATED, PH_CONNECTED, PH_NOTAVAIL:
				return $urandom_range(0, 1) ? CMD_EHLO : CMD_HELO;
			PH_MAILOK: return CMD_RCPT;
			PH_RCPTOK: return $urandom_range(0, 1) ? CMD_RCPT : CMD_DATA;
			PH_QUIT: return $urandom_range(0, 17);
			default: begin
				case ($urandom_range(0, 9))
					0: return CMD_AUTH;
					1: return CMD_TURN;
					2: return $urandom_range(0, 1) ? CMD_STLS : CMD_XTLS;
					3: return CMD_QUIT;
					4: return CMD_RSET;
					5: return $urandom_range(14, 26);
					default: return $urandom_range(2, 5);
				endcase
			end
		endcase
	endfunction

	// One reply, sometimes spread over several continued lines.
	task automatic reply_lines(input logic [9:0] rc);
		repeat ($urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0)
			server(rc, 1'b1, $urandom);
		server(rc, 1'b0, $urandom);
	endtask

	// One exchange of a plausible session, or a bit of noise now and then.
	task automatic session_step();
		int r, n;
		logic [4:0] c;
		r = $urandom_range(0, 99);
		if ((ph == PH_INTLS && r < 60) || r < 3) content_gap();
		else if (r < 13) send_word(1'b0, $urandom, $urandom, $urandom,
			$urandom_range(0, 1023), $urandom, $urandom);
		else if (ph == PH_INDATA) begin
			repeat ($urandom_range(0, 3)) client(CMD_UNK, 1'b0);
			client(CMD_UNK, 1'b1);
			reply_lines($urandom_range(0, 3) ? RC_250 : some_reply());
		end else if (ph == PH_AFTERGAP) begin
			client($urandom, $urandom);
			reply_lines($urandom_range(0, 1) ? RC_354 : some_reply());
		end else begin
			// With pipelining several commands go out before their replies.
			n = pipe_seen ? $urandom_range(1, 4) : 1;
			for (int i = 0; i < n; i++) begin
				c = fitting_cmd();
				client(c);
			end
			for (int i = 0; i < n; i++) begin
				case (c)
					CMD_DATA: reply_lines($urandom_range(0, 3) ? RC_354 : some_reply());
					CMD_AUTH: reply_lines($urandom_range(0, 1) ? RC_334 : some_reply());
					CMD_STLS, CMD_XTLS: reply_lines($urandom_range(0, 1) ? RC_220 : RC_554);
					default: reply_lines($urandom_range(0, 1) ? RC_250 : some_reply());
				endcase
			end
		end
	endtask

	// A full walk through the protocol, then the odd corners.
	task automatic test_directed();
		server(RC_220);                      // greeting answers the connection
		client(CMD_EHLO);
		server(RC_250, 1'b1, 1'b1);          // continued line, pipelining advertised
		server(RC_250, 1'b0, 1'b1);
		client(CMD_MAIL);
		client(CMD_RCPT);                    // pipelined behind MAIL
		server(RC_250);
		server(RC_250);
		client(CMD_DATA);
		server(RC_354);
		client(5'd0, 1'b0);                  // body line
		client(5'd0, 1'b1);                  // lone dot ends the mail
		server(RC_250);
		client(CMD_UNK);                     // unknown command
		client(CMD_EOD);                     // reserved codes count as unknown
		server(10'd1023);                    // reply without digits
		server(10'd99);
		server(10'd600);
		server(RC_MIN, 1'b1);
		server(RC_MAX);                      // continuation code mismatch
		client(CMD_AUTH);
		server(RC_334);
		client(CMD_MAIL);                    // taken as an auth answer
		server(10'd235);
		client(CMD_TURN);
		server(RC_250);                      // roles swap from here on
		server(RC_220);
		client(CMD_STLS);
		server(RC_220);                      // encrypted from here on
		client(CMD_QUIT);
		content_gap();
		server(RC_354);                      // gap recovery resumes data
		client(CMD_UNK, 1'b1);
		drain();
	endtask

	task automatic test_registers();
		logic [10:0] limits [6] = '{11'd1, 11'd0, 11'd2, 11'd2047, 11'd1024, 11'd3};
		foreach (limits[i]) begin
			write_reg(REG_PIPE_EN, 11'(i[0]));
			write_reg(REG_QLIMIT, limits[i]);
			content_gap();
			repeat (6) session_step();
		end
		write_reg(REG_PIPE_EN, 11'd1);
		write_reg(REG_QLIMIT, QLIMIT_RESET);
	endtask

	// The receiver holds off while words keep coming, so the input stalls.
	task automatic test_backpressure();
		drain();
		hold_req = 1'b1;
		repeat (12) session_step();
		drain();
	endtask

	task automatic test_random();
		int stop_at;
		stop_at = lines_sent + 250;
		while (lines_sent < stop_at) begin
			session_step();
			if ($urandom_range(0, 99) == 0) drain();
		end
	endtask

	initial begin
		model_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_registers();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0)
			$display("[smtp_session_tracker] OK");
		else
			$display("[smtp_session_tracker] ERROR");
		$finish;
	end

endmodule
